[hw/rtl/uabd_pkg.sv]
`default_nettype none

package uabd_pkg;

   localparam int CLOCK_W    = 27;
   localparam int BAUD_W     = 23;
   localparam int FRAC_W     = 4;
   localparam int IMO_W      = 16;
   localparam int WORD_W     = FRAC_W + IMO_W;
   localparam int INT_W      = CLOCK_W - FRAC_W;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   // one restoring step per quotient bit
   localparam int DIV_STEPS = CLOCK_W;

   localparam logic [CLOCK_W-1:0] CLOCK_RESET   = 27'h2625A00;
   localparam logic [INT_W-1:0]   INT_MAX_DIV   = 23'd65536;
   localparam logic [IMO_W-1:0]   IMO_SATURATED = 16'hFFFF;

   typedef struct packed {
      logic               valid;
      logic               zero_div;
      logic [BAUD_W-1:0]  divisor;
      logic [BAUD_W-1:0]  rem;
      logic [CLOCK_W-1:0] work;
   } div_stage_type;

endpackage

`default_nettype wire

[hw/rtl/uabd_div_step.sv]
`default_nettype none

module uabd_div_step (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    advance,
   input  uabd_pkg::div_stage_type stage_in,
   output uabd_pkg::div_stage_type stage_out
);
   import uabd_pkg::*;

   div_stage_type       stage_ff;
   div_stage_type       stage_in_c;
   logic [BAUD_W:0]     trial;
   logic [BAUD_W:0]     diff;
   logic                take;

   // shift the next dividend bit into the partial remainder and try a subtract
   always_comb begin
      trial      = {stage_in.rem, stage_in.work[CLOCK_W-1]};
      diff       = trial - {1'b0, stage_in.divisor};
      take       = (trial >= {1'b0, stage_in.divisor});
      stage_in_c = stage_in;
      stage_in_c.rem  = take ? diff[BAUD_W-1:0] : trial[BAUD_W-1:0];
      stage_in_c.work = {stage_in.work[CLOCK_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in_c;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

[hw/rtl/uabd_format.sv]
`default_nettype none

module uabd_format (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            advance,
   input  uabd_pkg::div_stage_type        stage_in,
   output logic                           out_valid,
   output logic [uabd_pkg::WORD_W-1:0]    baud_word,
   output logic [uabd_pkg::IMO_W-1:0]     int_minus_one,
   output logic [uabd_pkg::FRAC_W-1:0]    frac_part,
   output logic                           range_error
);
   import uabd_pkg::*;

   logic              valid_ff;
   logic [IMO_W-1:0]  imo_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic              err_ff;

   logic [INT_W-1:0]  int_div;
   logic [INT_W-1:0]  int_less_one;
   logic [IMO_W-1:0]  imo_in;
   logic [FRAC_W-1:0] frac_in;
   logic              err_in;

   // quotient of clock / baud: top bits are the integer divisor, low four the fraction
   always_comb begin
      int_div      = stage_in.work[CLOCK_W-1:FRAC_W];
      int_less_one = int_div - INT_W'(1);
      imo_in       = int_less_one[IMO_W-1:0];
      frac_in      = stage_in.work[FRAC_W-1:0];
      err_in       = 1'b0;
      if (stage_in.zero_div || (int_div > INT_MAX_DIV)) begin
         imo_in  = IMO_SATURATED;
         frac_in = '0;
         err_in  = 1'b1;
      end else if (int_div == '0) begin
         imo_in  = '0;
         frac_in = '0;
         err_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         imo_ff  <= imo_in;
         frac_ff <= frac_in;
         err_ff  <= err_in;
      end
   end

   assign out_valid     = valid_ff;
   assign baud_word     = {frac_ff, imo_ff};
   assign int_minus_one = imo_ff;
   assign frac_part     = frac_ff;
   assign range_error   = err_ff;

endmodule

`default_nettype wire

[hw/rtl/uart_baud_divisor_calculator_unit.sv]
// channel | dir | ports           | payload, lowest bit first
// req     | in  | req_t*          | bit_rate[22:0]
// rsp     | out | rsp_t*          | baud_word[19:0], int_minus_one[35:20],
//         |     |                 | frac_part[39:36], range_error[40]
// csr     | in  | csr_wr_*        | clock_hz[26:0]
//
// 27 restoring division steps, one quotient bit per stage, then the output register;
// one item may enter every cycle while the output item is not held
// the whole pipeline moves together and freezes while the output item waits
// reset clears the stage valid bits and loads clock_hz with 40 MHz
`default_nettype none

module uart_baud_divisor_calculator_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire [uabd_pkg::REQ_DATA_W-1:0]      req_tdata,  // bit_rate
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [uabd_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // baud_word, int_minus_one,
                                                           // frac_part, range_error
   input  wire                                 csr_wr_en,
   input  wire [uabd_pkg::CLOCK_W-1:0]         csr_wr_data // clock_hz
);
   import uabd_pkg::*;

   logic [CLOCK_W-1:0] clock_hz_ff;
   logic               advance;
   div_stage_type      entry;
   div_stage_type      stages [DIV_STEPS+1];

   logic [WORD_W-1:0]  baud_word;
   logic [IMO_W-1:0]   int_minus_one;
   logic [FRAC_W-1:0]  frac_part;
   logic               range_error;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= CLOCK_RESET;
      end else if (csr_wr_en) begin
         clock_hz_ff <= csr_wr_data;
      end
   end

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      entry.valid    = req_tvalid;
      entry.divisor  = req_tdata[BAUD_W-1:0];
      entry.zero_div = (req_tdata[BAUD_W-1:0] == '0);
      entry.rem      = '0;
      entry.work     = clock_hz_ff;
   end

   assign stages[0] = entry;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      uabd_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (stages[i]),
         .stage_out (stages[i+1])
      );
   end

   uabd_format u_format (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .stage_in      (stages[DIV_STEPS]),
      .out_valid     (rsp_tvalid),
      .baud_word     (baud_word),
      .int_minus_one (int_minus_one),
      .frac_part     (frac_part),
      .range_error   (range_error)
   );

   assign rsp_tdata = {{(RSP_DATA_W - WORD_W - IMO_W - FRAC_W - 1){1'b0}},
                       range_error, frac_part, int_minus_one, baud_word};

   // an error result carries only one of the two saturated values and no fraction
   a_error_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && range_error |->
         frac_part == '0 && (int_minus_one == '0 || int_minus_one == IMO_SATURATED))
      else $error("error result not saturated");

   // the packed word always agrees with the separate fields
   a_word_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> baud_word == {frac_part, int_minus_one})
      else $error("packed word disagrees with fields");

   // a stalled pipeline keeps its last division stage
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stages[DIV_STEPS]))
      else $error("division stage changed during stall");

   // an item reaching the last division stage shows up at the output next advance
   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      advance && stages[DIV_STEPS].valid |=> rsp_tvalid)
      else $error("item lost at output register");

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import uabd_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [IMO_W-1:0]  imo;
      logic [FRAC_W-1:0] frac;
      logic              err;
   } divisor_result_type;

   typedef struct packed {
      logic               is_cfg;
      logic               typed;
      logic [CLOCK_W-1:0] value;
      divisor_result_type exp;
   } stim_row_type;

   localparam divisor_result_type RES_SAT  =
      '{word: 20'h0FFFF, imo: 16'hFFFF, frac: 4'd0, err: 1'b1};
   localparam divisor_result_type RES_ZERO =
      '{word: 20'h00000, imo: 16'h0000, frac: 4'd0, err: 1'b1};
   localparam divisor_result_type RES_ONE  =
      '{word: 20'h00000, imo: 16'h0000, frac: 4'd0, err: 1'b0};
   localparam divisor_result_type RES_TOP  =
      '{word: 20'h0FFFF, imo: 16'hFFFF, frac: 4'd0, err: 1'b0};

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 116;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int HOLD_OFF_CYCLES = 100;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;  // bit_rate
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // baud_word, int_minus_one, frac_part, range_error
   logic                  csr_wr_en   = 1'b0;
   logic [CLOCK_W-1:0]    csr_wr_data = '0;  // clock_hz

   divisor_result_type divisor_q [$];
   divisor_result_type rsp_got;
   divisor_result_type rsp_want;
   logic [CLOCK_W-1:0] cur_clock_hz = CLOCK_RESET;
   int unsigned baud_sent      = 0;
   int unsigned divisors_seen  = 0;
   int unsigned range_errors   = 0;
   int unsigned clock_settings = 0;
   int unsigned mismatches     = 0;
   int unsigned stall_cycles   = 0;
   logic        held_off       = 1'b0;

   uart_baud_divisor_calculator_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic divisor_result_type calc_divisor(input logic [CLOCK_W-1:0] clk_hz,
                                                       input logic [BAUD_W-1:0] baud);
      logic [63:0] clk64;
      logic [63:0] baud16;
      logic [63:0] quot;
      logic [63:0] rem;
      logic [63:0] frac;
      divisor_result_type r;
      clk64  = 64'(clk_hz);
      baud16 = 64'(baud) << 4;
      r      = '0;
      r.err  = 1'b1;
      // zero baud counts as an all-ones quotient, so it saturates high
      if (baud16 == 64'd0) begin
         r.imo = IMO_SATURATED;
      end else begin
         quot = clk64 / baud16;
         if (quot == 64'd0) begin
            r.imo = '0;
         end else if (quot > 64'd65536) begin
            r.imo = IMO_SATURATED;
         end else begin
            rem   = clk64 - quot * baud16;
            frac  = (rem << 4) / baud16;
            r.imo  = IMO_W'(quot - 64'd1);
            r.frac = frac[FRAC_W-1:0];
            r.err  = 1'b0;
         end
      end
      r.word = {r.frac, r.imo};
      return r;
   endfunction

   function automatic logic [BAUD_W-1:0] pick_baud(input logic [CLOCK_W-1:0] clk_hz);
      logic [63:0] b;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         // aim at a random divisor so most requests land in the legal range
         b = 64'(clk_hz) / (64'd16 * 64'($urandom_range(1, 65536)))
             + 64'($urandom_range(0, 2));
      end else if (sel < 65) begin
         case ($urandom_range(0, 9))
            0:       b = 64'd300;
            1:       b = 64'd1200;
            2:       b = 64'd9600;
            3:       b = 64'd19200;
            4:       b = 64'd57600;
            5:       b = 64'd115200;
            6:       b = 64'd460800;
            7:       b = 64'd921600;
            8:       b = 64'd3000000;
            default: b = 64'd6250000;
         endcase
      end else if (sel < 80) begin
         b = 64'($urandom);
      end else if (sel < 90) begin
         b = 64'($urandom_range(0, 64));
      end else if (sel < 95) begin
         // around an integer divisor of 65536
         b = 64'(clk_hz) / 64'd1048576 + 64'($urandom_range(0, 2)) - 64'd1;
      end else begin
         // around an integer divisor of one
         b = 64'(clk_hz) / 64'd16 + 64'($urandom_range(0, 2)) - 64'd1;
      end
      return b[BAUD_W-1:0];
   endfunction

   function automatic int unsigned next_gap(input logic no_gaps);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (no_gaps || sel < 70) return 0;
      if (sel < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic stim_row_type clock_row(input logic [CLOCK_W-1:0] v);
      clock_row        = '0;
      clock_row.is_cfg = 1'b1;
      clock_row.value  = v;
   endfunction

   function automatic stim_row_type baud_row(input logic [BAUD_W-1:0] b);
      baud_row       = '0;
      baud_row.value = CLOCK_W'(b);
   endfunction

   function automatic stim_row_type baud_row_exp(input logic [BAUD_W-1:0] b,
                                                 input divisor_result_type r);
      baud_row_exp       = baud_row(b);
      baud_row_exp.typed = 1'b1;
      baud_row_exp.exp   = r;
   endfunction

   task automatic send_baud(input logic [BAUD_W-1:0] baud, input int unsigned gap,
                            input logic typed, input divisor_result_type typed_res);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, baud};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      divisor_q.push_back(typed ? typed_res : calc_divisor(cur_clock_hz, baud));
      baud_sent++;
   endtask

   // only once the pipeline has drained
   task automatic write_clock(input logic [CLOCK_W-1:0] value);
      req_tvalid <= 1'b0;
      while (divisor_q.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      cur_clock_hz  = value;
      clock_settings++;
   endtask

   initial begin
      stim_row_type rows [28];
      logic no_gaps;
      rows = '{
         baud_row_exp(23'd0, RES_SAT),
         baud_row_exp(23'd1, RES_SAT),
         baud_row_exp(23'd6250000, RES_ZERO),
         baud_row_exp(23'd2500000, RES_ONE),
         baud_row(23'd115200),
         baud_row(23'd9600),
         baud_row_exp(23'h7FFFFF, RES_ZERO),
         baud_row(23'd39),
         baud_row_exp(23'd38, RES_SAT),
         baud_row(23'h555555),
         baud_row(23'h2AAAAA),
         clock_row(27'd1048576),
         baud_row_exp(23'd1, RES_TOP),
         baud_row(23'd2),
         clock_row(27'd1048577),
         baud_row(23'd1),
         clock_row(27'd0),
         baud_row_exp(23'd1, RES_ZERO),
         baud_row_exp(23'd0, RES_SAT),
         clock_row(27'h7FFFFFF),
         baud_row_exp(23'd1, RES_SAT),
         baud_row(23'h7FFFFF),
         baud_row(23'h400000),
         clock_row(27'd100000000),
         baud_row_exp(23'd6250000, RES_ONE),
         baud_row(23'd115200),
         clock_row(27'd1),
         baud_row_exp(23'd1, RES_ZERO)
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].is_cfg) begin
            write_clock(rows[i].value);
         end else begin
            send_baud(rows[i].value[BAUD_W-1:0], next_gap(1'b0), rows[i].typed, rows[i].exp);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       write_clock(CLOCK_W'($urandom_range(1, 100000000)));
            1:       write_clock(27'd100000000);
            2:       write_clock(27'd40000000);
            3:       write_clock(CLOCK_W'($urandom_range(1000000, 100000000)));
            4:       write_clock(27'h7FFFFFF);
            5:       write_clock(27'd1);
            6:       write_clock(CLOCK_W'($urandom));
            default: write_clock(27'd14745600);
         endcase
         no_gaps = ($urandom_range(0, 2) == 0);
         repeat (ITEMS_PER_PHASE) begin
            send_baud(pick_baud(cur_clock_hz), next_gap(no_gaps), 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (divisor_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d baud requests under %0d clock settings,", baud_sent, clock_settings);
      $display("%0d divisors checked (%0d out of range)", divisors_seen, range_errors);
      if (mismatches == 0) begin
         $display("PASS uart_baud_divisor_calculator_unit");
      end else begin
         $display("FAIL uart_baud_divisor_calculator_unit");
      end
      $finish;
   end

   // output side: random back-pressure plus one long hold-off to fill the pipeline
   initial begin
      int unsigned len;
      int unsigned sel;
      wait (!reset);
      @(posedge clock);
      forever begin
         sel = $urandom_range(0, 99);
         if (!held_off && baud_sent >= 60) begin
            rsp_tready <= 1'b0;
            len         = HOLD_OFF_CYCLES;
            held_off    = 1'b1;
         end else if (sel < 55) begin
            rsp_tready <= 1'b1;
            len         = $urandom_range(1, 12);
         end else if (sel < 65) begin
            rsp_tready <= 1'b1;
            len         = $urandom_range(50, 200);
         end else if (sel < 93) begin
            rsp_tready <= 1'b0;
            len         = $urandom_range(1, 3);
         end else begin
            rsp_tready <= 1'b0;
            len         = $urandom_range(10, 40);
         end
         repeat (len) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_got = '{word: rsp_tdata[19:0], imo: rsp_tdata[35:20],
                     frac: rsp_tdata[39:36], err: rsp_tdata[40]};
         divisors_seen++;
         if (rsp_got.err) range_errors++;
         if (divisor_q.size() == 0) begin
            $error("divisor item with nothing outstanding: %h", rsp_tdata);
            mismatches++;
         end else begin
            rsp_want = divisor_q.pop_front();
            if (rsp_got.word != rsp_want.word) begin
               $error("baud_word: expected %h, got %h", rsp_want.word, rsp_got.word);
               mismatches++;
            end
            if (rsp_got.imo != rsp_want.imo) begin
               $error("int_minus_one: expected %0d, got %0d", rsp_want.imo, rsp_got.imo);
               mismatches++;
            end
            if (rsp_got.frac != rsp_want.frac) begin
               $error("frac_part: expected %0d, got %0d", rsp_want.frac, rsp_got.frac);
               mismatches++;
            end
            if (rsp_got.err != rsp_want.err) begin
               $error("range_error: expected %0d, got %0d", rsp_want.err, rsp_got.err);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $error("no handshake for %0d cycles, %0d divisors outstanding",
                stall_cycles, divisor_q.size());
         $display("FAIL uart_baud_divisor_calculator_unit");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

[sim.f]
hw/rtl/uabd_pkg.sv
hw/rtl/uabd_div_step.sv
hw/rtl/uabd_format.sv
hw/rtl/uart_baud_divisor_calculator_unit.sv
dv/testbench.sv
